@@ hw/rtl/ssp_pkg.sv @@
// ssp_pkg: word types, status struct and fixed constants of the spike snippet packetizer
// no dependencies; imported by ssp_front, ssp_queue and spike_snippet_packetizer
package ssp_pkg;

   localparam int RING_DEPTH      = 32;
   localparam int SLOT_W          = 5;
   localparam int COUNT_W         = 4;
   localparam int WORD_W          = 33;
   localparam int NUM_CHANNELS    = 32;
   localparam int PRE_LEN         = 8;
   localparam int SPIKE_LEN       = 19;
   localparam int QUEUE_DEPTH_DEF = 4;

   typedef struct packed {
      logic [4:0]        channel;
      logic signed [31:0] frame;
      logic [32:0]       sample_word;
   } ssp_req_type;

   typedef struct packed {
      logic [4:0]        out_channel;
      logic              pre_valid;
      logic [3:0]        pre_index;
      logic [32:0]       pre_word;
      logic              pre_last;
      logic              post_valid;
      logic [4:0]        post_index;
      logic [32:0]       post_word;
      logic              post_last;
      logic              stamp_valid;
      logic signed [31:0] stamp_frame;
      logic [31:0]       busy_flags;
   } ssp_rsp_type;

   typedef struct packed {
      logic clearing;
      logic inflight;
   } ssp_front_status_type;

endpackage

@@ hw/rtl/ssp_ram.sv @@
// ssp_ram: generic one-write one-read RAM with registered read data
// no dependencies; used by ssp_front for the sample ring
module ssp_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/ssp_front.sv @@
// ssp_front: accepts words, runs the per-channel snippet machines, owns the sample ring
// depends on ssp_pkg and ssp_ram
module ssp_front #(
   parameter int CHANNELS = ssp_pkg::NUM_CHANNELS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_accept,
   input  ssp_pkg::ssp_req_type         in_data,
   output logic                         res_valid,
   output ssp_pkg::ssp_rsp_type         res,
   output ssp_pkg::ssp_front_status_type status
);
   import ssp_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_PRE  = 2'd1,
      PH_POST = 2'd2
   } phase_type;

   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CH_SLOTS  = 1 << CH_W;
   localparam int ADDR_W    = SLOT_W + CH_W;
   localparam int RAM_DEPTH = RING_DEPTH << CH_W;
   localparam int POST_END  = SPIKE_LEN - PRE_LEN - 1;

   phase_type          phase_ff [CH_SLOTS];
   logic [COUNT_W-1:0] count_ff [CH_SLOTS];
   logic [31:0]        overlap_ff;
   logic               clear_ff;
   logic [ADDR_W-1:0]  clear_addr_ff;
   logic               s1_valid_ff;
   ssp_rsp_type        s1_ff;

   phase_type          phase_in;
   logic [COUNT_W-1:0] count_in;
   logic [31:0]        overlap_in;
   ssp_rsp_type        s1_in;

   logic [CH_W-1:0]    ch_idx;
   logic               in_range;
   logic [SLOT_W-1:0]  slot;
   logic [SLOT_W-1:0]  pslot;
   logic               peak;
   phase_type          cur_phase;
   logic [COUNT_W-1:0] cnt;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [WORD_W-1:0]  ram_wr_data;
   logic [WORD_W-1:0]  ram_rd_data;

   assign ch_idx    = in_data.channel[CH_W-1:0];
   assign in_range  = int'(in_data.channel) < CHANNELS;
   assign slot      = in_data.frame[SLOT_W-1:0];
   assign pslot     = slot - SLOT_W'(PRE_LEN);
   assign peak      = in_data.sample_word[WORD_W-1];
   assign cur_phase = phase_ff[ch_idx];
   assign cnt       = count_ff[ch_idx];

   always_comb begin
      phase_in              = cur_phase;
      count_in              = cnt;
      overlap_in            = overlap_ff;
      s1_in                 = '0;
      s1_in.out_channel     = in_data.channel;
      s1_in.busy_flags      = overlap_ff;
      if (in_range) begin
         unique case (cur_phase)
            PH_IDLE: begin
               if (peak) begin
                  s1_in.pre_valid  = 1'b1;
                  s1_in.post_valid = 1'b1;
                  s1_in.post_index = 5'(PRE_LEN);
                  s1_in.post_word  = in_data.sample_word;
                  phase_in         = PH_PRE;
                  count_in         = cnt + COUNT_W'(1);
               end else begin
                  count_in                    = '0;
                  overlap_in[in_data.channel] = 1'b0;
               end
            end
            PH_PRE: begin
               if (peak) begin
                  overlap_in[in_data.channel] = 1'b1;
               end
               if (int'(cnt) <= PRE_LEN - 1) begin
                  s1_in.pre_valid  = 1'b1;
                  s1_in.pre_index  = cnt;
                  s1_in.post_valid = 1'b1;
                  s1_in.post_index = 5'(cnt) + 5'(PRE_LEN);
                  s1_in.post_word  = in_data.sample_word;
                  count_in         = cnt + COUNT_W'(1);
                  if (int'(cnt) == PRE_LEN - 1) begin
                     s1_in.pre_last = 1'b1;
                     phase_in       = PH_POST;
                  end
               end else begin
                  phase_in = PH_IDLE;
                  count_in = '0;
               end
            end
            PH_POST: begin
               if (peak) begin
                  overlap_in[in_data.channel] = 1'b1;
               end
               if (int'(cnt) < POST_END) begin
                  s1_in.post_valid = 1'b1;
                  s1_in.post_index = 5'(cnt) + 5'(PRE_LEN);
                  s1_in.post_word  = in_data.sample_word;
                  count_in         = cnt + COUNT_W'(1);
               end else if (int'(cnt) == POST_END) begin
                  s1_in.post_valid  = 1'b1;
                  s1_in.post_index  = 5'(cnt) + 5'(PRE_LEN);
                  s1_in.post_word   = in_data.sample_word;
                  s1_in.post_last   = 1'b1;
                  s1_in.stamp_valid = 1'b1;
                  s1_in.stamp_frame = in_data.frame - 32'(POST_END);
                  phase_in          = PH_IDLE;
                  count_in          = '0;
               end else begin
                  phase_in = PH_IDLE;
                  count_in = '0;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               count_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CH_SLOTS; i++) begin
            phase_ff[i] <= PH_IDLE;
            count_ff[i] <= '0;
         end
         overlap_ff    <= '0;
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         if (clear_ff) begin
            clear_addr_ff <= clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == '1) begin
               clear_ff <= 1'b0;
            end
         end
         s1_valid_ff <= in_accept;
         if (in_accept) begin
            s1_ff <= s1_in;
         end
         if (in_accept && in_range) begin
            phase_ff[ch_idx] <= phase_in;
            count_ff[ch_idx] <= count_in;
            overlap_ff       <= overlap_in;
         end
      end
   end

   // ring write is the clearing sweep or the accepted word; read is PRE_LEN frames back
   assign ram_wr_en   = clear_ff | (in_accept & in_range);
   assign ram_wr_addr = clear_ff ? clear_addr_ff : {slot, ch_idx};
   assign ram_wr_data = clear_ff ? '0 : in_data.sample_word;

   ssp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (RAM_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (in_accept),
      .rd_addr ({pslot, ch_idx}),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      res = s1_ff;
      if (s1_ff.pre_valid) begin
         res.pre_word = ram_rd_data;
      end
   end

   assign res_valid       = s1_valid_ff;
   assign status.clearing = clear_ff;
   assign status.inflight = s1_valid_ff;

   a_res_follows_accept: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> $past(in_accept))
      else $error("result word without an accepted word one cycle earlier");

   a_stamp_on_last: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.stamp_valid) |-> (res.post_valid && res.post_last))
      else $error("stamp given on a word that does not end the snippet");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !in_accept)
      else $error("word accepted during ring clearing sweep");

endmodule

@@ hw/rtl/ssp_queue.sv @@
// ssp_queue: short result queue between the front and the result port
// depends on ssp_pkg
module ssp_queue #(
   parameter int DEPTH = ssp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ssp_pkg::ssp_rsp_type       push_data,
   input  logic                       pop,
   output ssp_pkg::ssp_rsp_type       pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import ssp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ssp_rsp_type      mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_in;

   assign wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            mem_ff[wr_ptr_ff] <= push_data;
            wr_ptr_ff         <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (int'(count_ff) < DEPTH))
      else $error("word pushed into a full result queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("word popped from an empty result queue");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= DEPTH)
      else $error("result queue holds more words than its depth");

endmodule

@@ hw/rtl/spike_snippet_packetizer.sv @@
// spike_snippet_packetizer: top level, front (snippet machines, sample ring) and result queue
// depends on ssp_pkg, ssp_front, ssp_queue
//
//   channel   ports                          word
//   req       req_push / req_full            ssp_req_type: channel, frame, sample_word
//   rsp       rsp_pop / rsp_empty            ssp_rsp_type: pre, post, stamp, busy_flags
//
// one word accepted per cycle while req_full is low; each result passes through the front's
// result register and then the result queue before it can be popped from rsp_data
// reset clears all channel machines, then a sweep writes every ring entry to zero, one
// entry a cycle, with req_full held high
// req_full rises while the result queue has no room for a word beyond those already in flight
module spike_snippet_packetizer #(
   parameter int CHANNELS    = ssp_pkg::NUM_CHANNELS,
   parameter int QUEUE_DEPTH = ssp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  ssp_pkg::ssp_req_type req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output ssp_pkg::ssp_rsp_type rsp_data
);
   import ssp_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                 accept;
   logic                 res_valid;
   ssp_rsp_type          res;
   ssp_front_status_type front_status;
   logic [CNT_W-1:0]     q_count;
   logic                 q_empty;

   assign accept   = req_push & ~req_full;
   assign req_full = front_status.clearing
                   | ((int'(q_count) + int'(front_status.inflight)) >= QUEUE_DEPTH);

   ssp_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_data   (req_data),
      .res_valid (res_valid),
      .res       (res),
      .status    (front_status)
   );

   ssp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .pop       (rsp_pop & ~q_empty),
      .pop_data  (rsp_data),
      .empty     (q_empty),
      .count     (q_count)
   );

   assign rsp_empty = q_empty;

endmodule
